FILE: design/trigger_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// Trigger packet deframer assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIGGER_PACKET_DEFRAMER_DEFINES_SVH
`define TRIGGER_PACKET_DEFRAMER_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define TPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must be followed by a consequence in the next cycle
`define TPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tpd_pkg.sv
// ----------------------------------------------------------------------------
// Trigger packet deframer package
// Shared constants, queue entry type and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

    localparam int WORD_W           = 32;
    localparam int WORDS_PER_PACKET = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam int SAMPLE_W  = 12;
    localparam int FRAME_W   = 24;
    localparam int TRIGGER_W = 24;
    localparam int PMT_W     = 8;
    localparam int FLAGS_W   = 7;
    localparam int RFAST_W   = 2;
    localparam int RSLOW_W   = 3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_MARKER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESYNC     = 1'b1;

    // Classification of one accepted word
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_FERR = 2'd2
    } tpd_kind_t;

    // One request from the front end to the back end
    typedef struct packed {
        tpd_kind_t          kind;
        logic [WORD_W-1:0]  w0;
        logic [WORD_W-1:0]  w1;
        logic [WORD_W-1:0]  w2;
        logic [WORD_W-1:0]  checksum;
        logic [WORD_W-1:0]  total;
    } tpd_entry_t;

    // Queue occupancy seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } tpd_queue_status_t;

endpackage

`default_nettype wire

FILE: design/tpd_word_if.sv
// ----------------------------------------------------------------------------
// Trigger word channel
// Valid/ready channel carrying one raw readout word per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tpd_word_if;

    logic                      valid;
    logic                      ready;
    logic [tpd_pkg::WORD_W-1:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);

endinterface

`default_nettype wire

FILE: design/tpd_result_if.sv
// ----------------------------------------------------------------------------
// Trigger result channel
// Valid/ready channel carrying one decoded result per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tpd_result_if;

    logic                          valid;
    logic                          ready;
    logic                          packet_done;
    logic                          framing_error;
    logic [tpd_pkg::SAMPLE_W-1:0]  sample_number;
    logic [tpd_pkg::FRAME_W-1:0]   frame_number;
    logic [tpd_pkg::TRIGGER_W-1:0] trigger_number;
    logic [tpd_pkg::PMT_W-1:0]     pmt_bits;
    logic [tpd_pkg::FLAGS_W-1:0]   trigger_flags;
    logic [tpd_pkg::RFAST_W-1:0]   remainder_fast;
    logic [tpd_pkg::RSLOW_W-1:0]   remainder_slow;
    logic                          sequence_gap;
    logic [tpd_pkg::WORD_W-1:0]    running_checksum;
    logic [tpd_pkg::WORD_W-1:0]    word_total;

    modport source (
        output valid, input ready,
        output packet_done, output framing_error, output sample_number,
        output frame_number, output trigger_number, output pmt_bits,
        output trigger_flags, output remainder_fast, output remainder_slow,
        output sequence_gap, output running_checksum, output word_total
    );
    modport sink (
        input valid, output ready,
        input packet_done, input framing_error, input sample_number,
        input frame_number, input trigger_number, input pmt_bits,
        input trigger_flags, input remainder_fast, input remainder_slow,
        input sequence_gap, input running_checksum, input word_total
    );

endinterface

`default_nettype wire

FILE: design/tpd_front.sv
// ----------------------------------------------------------------------------
// Trigger packet deframer front end
// Gathers words into the packet buffer, checks the end marker and classifies
// each word, keeping the running checksum and word total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "trigger_packet_deframer_defines.svh"

module tpd_front #(
    parameter int WORDS_PER_PACKET = tpd_pkg::WORDS_PER_PACKET
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tpd_word_if.sink                            data_in,
    input  wire logic [tpd_pkg::WORD_W-1:0]     end_marker,
    input  wire logic                           resync_on_error,
    input  wire tpd_pkg::tpd_queue_status_t     queue_status,
    output logic                                push,
    output tpd_pkg::tpd_entry_t                 push_entry
);

    localparam int FILL_W = $clog2(WORDS_PER_PACKET + 1);
    localparam int IDX_W  = $clog2(WORDS_PER_PACKET);

    logic [tpd_pkg::WORD_W-1:0] buf_reg  [WORDS_PER_PACKET];
    logic [tpd_pkg::WORD_W-1:0] buf_fill [WORDS_PER_PACKET];
    logic [tpd_pkg::WORD_W-1:0] buf_next [WORDS_PER_PACKET];
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          fill_next;
    logic [tpd_pkg::WORD_W-1:0] checksum_reg;
    logic [tpd_pkg::WORD_W-1:0] checksum_next;
    logic [tpd_pkg::WORD_W-1:0] total_reg;
    logic [tpd_pkg::WORD_W-1:0] total_next;
    logic [IDX_W-1:0]           slot;
    logic                       last_slot;

    // Accept whenever the queue has room
    assign data_in.ready = !queue_status.full;
    assign push          = data_in.valid && data_in.ready;

    // Store the word, check the end marker and classify
    always_comb
    begin
        slot = (fill_reg >= FILL_W'(WORDS_PER_PACKET)) ? '0 : fill_reg[IDX_W-1:0];
        buf_fill       = buf_reg;
        buf_fill[slot] = data_in.data_word;
        last_slot      = (slot == IDX_W'(WORDS_PER_PACKET - 1));
        buf_next       = buf_fill;
        fill_next      = FILL_W'(slot) + FILL_W'(1);
        checksum_next  = checksum_reg + data_in.data_word;
        total_next     = total_reg + tpd_pkg::WORD_W'(1);

        push_entry.kind     = tpd_pkg::KIND_NONE;
        push_entry.w0       = buf_fill[0];
        push_entry.w1       = buf_fill[1];
        push_entry.w2       = buf_fill[2];
        push_entry.checksum = checksum_next;
        push_entry.total    = total_next;

        if (last_slot)
        begin
            if (data_in.data_word != end_marker)
            begin
                push_entry.kind = tpd_pkg::KIND_FERR;
                if (resync_on_error)
                begin
                    // Drop the oldest word and keep the rest
                    for (int i = 0; i < WORDS_PER_PACKET - 1; i++)
                    begin
                        buf_next[i] = buf_fill[i + 1];
                    end
                    buf_next[WORDS_PER_PACKET - 1] = '0;
                    fill_next = FILL_W'(WORDS_PER_PACKET - 1);
                end
                else
                begin
                    fill_next = '0;
                end
            end
            else
            begin
                push_entry.kind = tpd_pkg::KIND_DONE;
                fill_next       = '0;
            end
        end
    end

    // Advance the control state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            checksum_reg <= '0;
            total_reg    <= '0;
        end
        else if (push)
        begin
            fill_reg     <= fill_next;
            checksum_reg <= checksum_next;
            total_reg    <= total_next;
        end
    end

    // Hold the packet words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg <= buf_next;
        end
    end

    `TPD_ASSERT(a_fill_range, fill_reg < FILL_W'(WORDS_PER_PACKET), "fill count out of range")
    `TPD_ASSERT_NEXT(a_resync_fill, push && push_entry.kind == tpd_pkg::KIND_FERR && resync_on_error, fill_reg == FILL_W'(WORDS_PER_PACKET - 1), "resync did not keep the packet tail")

endmodule

`default_nettype wire

FILE: design/tpd_queue.sv
// ----------------------------------------------------------------------------
// Trigger packet deframer request queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "trigger_packet_deframer_defines.svh"

module tpd_queue #(
    parameter int DEPTH = tpd_pkg::QUEUE_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire tpd_pkg::tpd_entry_t        push_entry,
    input  wire logic                       pop,
    output tpd_pkg::tpd_entry_t             head,
    output tpd_pkg::tpd_queue_status_t      status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tpd_pkg::tpd_entry_t store_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign head         = store_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    // Advance pointers with wrap and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `TPD_ASSERT(a_count_range, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `TPD_ASSERT_NEXT(a_full_holds, status.full && !pop, status.full, "full queue lost an entry")

endmodule

`default_nettype wire

FILE: design/tpd_back.sv
// ----------------------------------------------------------------------------
// Trigger packet deframer back end
// Decodes queued requests into result fields, checks trigger continuity and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "trigger_packet_deframer_defines.svh"

module tpd_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tpd_pkg::tpd_entry_t            head,
    input  wire tpd_pkg::tpd_queue_status_t     queue_status,
    output logic                                pop,
    tpd_result_if.source                        result_out
);

    logic                            valid_reg;
    logic [tpd_pkg::TRIGGER_W-1:0]   prev_trigger_reg;
    logic                            done_reg;
    logic                            ferr_reg;
    logic [tpd_pkg::SAMPLE_W-1:0]    sample_reg;
    logic [tpd_pkg::FRAME_W-1:0]     frame_reg;
    logic [tpd_pkg::TRIGGER_W-1:0]   trigger_reg;
    logic [tpd_pkg::PMT_W-1:0]       pmt_reg;
    logic [tpd_pkg::FLAGS_W-1:0]     flags_reg;
    logic [tpd_pkg::RFAST_W-1:0]     rfast_reg;
    logic [tpd_pkg::RSLOW_W-1:0]     rslow_reg;
    logic                            gap_reg;
    logic [tpd_pkg::WORD_W-1:0]      checksum_reg;
    logic [tpd_pkg::WORD_W-1:0]      total_reg;

    logic                            done_next;
    logic                            ferr_next;
    logic [tpd_pkg::SAMPLE_W-1:0]    sample_next;
    logic [tpd_pkg::FRAME_W-1:0]     frame_next;
    logic [tpd_pkg::TRIGGER_W-1:0]   trigger_next;
    logic [tpd_pkg::PMT_W-1:0]       pmt_next;
    logic [tpd_pkg::FLAGS_W-1:0]     flags_next;
    logic [tpd_pkg::RFAST_W-1:0]     rfast_next;
    logic [tpd_pkg::RSLOW_W-1:0]     rslow_next;
    logic                            gap_next;
    logic [tpd_pkg::TRIGGER_W-1:0]   trig_field;

    // Take the next request when the output register is free
    assign pop = !queue_status.empty && (!valid_reg || result_out.ready);

    // Decode the head request
    always_comb
    begin
        trig_field   = head.w1[31:8];
        done_next    = 1'b0;
        ferr_next    = 1'b0;
        sample_next  = '0;
        frame_next   = '0;
        trigger_next = '0;
        pmt_next     = '0;
        flags_next   = '0;
        rfast_next   = '0;
        rslow_next   = '0;
        gap_next     = 1'b0;
        unique case (head.kind)
            tpd_pkg::KIND_DONE:
            begin
                done_next    = 1'b1;
                sample_next  = head.w0[15:4];
                frame_next   = {head.w1[7:0], head.w0[31:16]};
                trigger_next = trig_field;
                pmt_next     = head.w2[7:0];
                flags_next   = {head.w2[14], head.w2[13], head.w2[11], head.w2[12],
                                head.w2[10], head.w2[9], head.w2[8]};
                rfast_next   = head.w2[16:15];
                rslow_next   = head.w0[3:1];
                gap_next     = (trig_field != '0) &&
                               (trig_field != prev_trigger_reg + tpd_pkg::TRIGGER_W'(1));
            end
            tpd_pkg::KIND_FERR:
            begin
                ferr_next = 1'b1;
            end
            tpd_pkg::KIND_NONE:
            begin
                done_next = 1'b0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state: output valid and last good trigger number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            prev_trigger_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                valid_reg <= 1'b0;
            end
            if (pop && done_next)
            begin
                prev_trigger_reg <= trigger_next;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            done_reg     <= done_next;
            ferr_reg     <= ferr_next;
            sample_reg   <= sample_next;
            frame_reg    <= frame_next;
            trigger_reg  <= trigger_next;
            pmt_reg      <= pmt_next;
            flags_reg    <= flags_next;
            rfast_reg    <= rfast_next;
            rslow_reg    <= rslow_next;
            gap_reg      <= gap_next;
            checksum_reg <= head.checksum;
            total_reg    <= head.total;
        end
    end

    assign result_out.valid            = valid_reg;
    assign result_out.packet_done      = done_reg;
    assign result_out.framing_error    = ferr_reg;
    assign result_out.sample_number    = sample_reg;
    assign result_out.frame_number     = frame_reg;
    assign result_out.trigger_number   = trigger_reg;
    assign result_out.pmt_bits         = pmt_reg;
    assign result_out.trigger_flags    = flags_reg;
    assign result_out.remainder_fast   = rfast_reg;
    assign result_out.remainder_slow   = rslow_reg;
    assign result_out.sequence_gap     = gap_reg;
    assign result_out.running_checksum = checksum_reg;
    assign result_out.word_total       = total_reg;

    `TPD_ASSERT(a_one_flag, !(valid_reg && done_reg && ferr_reg), "done and framing error together")
    `TPD_ASSERT_NEXT(a_prev_tracks, pop && done_next, prev_trigger_reg == trigger_reg, "trigger history not updated")

endmodule

`default_nettype wire

FILE: design/trigger_packet_deframer.sv
// A result is valid once its word has passed through the queue and then the output register.
// Throughput: one word per cycle while result_out.ready holds, as a full queue stalls data_in;
// results are taken one per cycle through the two-entry request queue and the output register.
// Reset: asynchronous active low; clears fill count, checksum, word total, last trigger,
// configuration registers and all valid state. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Trigger packet deframer
// Top level: configuration registers, front end, request queue, back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trigger_packet_deframer #(
    parameter int WORDS_PER_PACKET = tpd_pkg::WORDS_PER_PACKET,
    parameter int QUEUE_DEPTH      = tpd_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tpd_word_if.sink                               data_in,
    tpd_result_if.source                           result_out,
    input  wire logic                              cfg_we,
    input  wire logic [tpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tpd_pkg::WORD_W-1:0]        cfg_data
);

    logic [tpd_pkg::WORD_W-1:0]    end_marker_reg;
    logic                          resync_reg;
    logic                          push;
    logic                          pop;
    tpd_pkg::tpd_entry_t           push_entry;
    tpd_pkg::tpd_entry_t           head;
    tpd_pkg::tpd_queue_status_t    queue_status;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg <= '0;
            resync_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpd_pkg::CFG_END_MARKER: end_marker_reg <= cfg_data;
                tpd_pkg::CFG_RESYNC:     resync_reg     <= cfg_data[0];
                default:                 resync_reg     <= resync_reg;
            endcase
        end
    end

    tpd_front #(
        .WORDS_PER_PACKET (WORDS_PER_PACKET)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_in         (data_in),
        .end_marker      (end_marker_reg),
        .resync_on_error (resync_reg),
        .queue_status    (queue_status),
        .push            (push),
        .push_entry      (push_entry)
    );

    tpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (queue_status)
    );

    tpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .queue_status (queue_status),
        .pop          (pop),
        .result_out   (result_out)
    );

endmodule

`default_nettype wire
